[sv/sorted_block_entry_parser_core_assert.svh]
`ifndef SORTED_BLOCK_ENTRY_PARSER_CORE_ASSERT_SVH
`define SORTED_BLOCK_ENTRY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SBEP_ASSERT_IMP(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("sbep: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SBEP_ASSERT_NXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("sbep: next-cycle check failed");

`endif

[sv/sbep_pkg.sv]
package sbep_pkg;

  localparam int unsigned OFFS_W = 17;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned BLOCK_BYTES_LIMIT_DEF = 65536;
  localparam int unsigned CFG_ADDR_W = 3;

  // Parse phases.
  localparam logic [2:0] PH_SHARED = 3'd0;
  localparam logic [2:0] PH_DELTA  = 3'd1;
  localparam logic [2:0] PH_VALUE  = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_VAL    = 3'd4;
  localparam logic [2:0] PH_HALT   = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_KEY     = 2'd1;
  localparam logic [1:0] KIND_VALUE   = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  // Register index decoded from the word address.
  localparam logic REG_DATA_LENGTH = 1'b0;

  typedef struct packed {
    logic [2:0]        phase;
    logic [OFFS_W-1:0] offset;
    logic [LEN_W-1:0]  accum;
    logic [2:0]        count;
    logic [LEN_W-1:0]  shared_len;
    logic [LEN_W-1:0]  delta_len;
    logic [OFFS_W-1:0] value_len;
    logic [OFFS_W-1:0] body_count;
    logic [OFFS_W-1:0] prev_key_len;
  } sbep_state_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] shared_bytes;
    logic [FIELD_W-1:0] delta_bytes;
    logic [FIELD_W-1:0] value_bytes;
    logic               entry_done;
    logic               block_done;
  } sbep_res_t;

endpackage

[sv/sbep_step.sv]
module sbep_step (
  input  sbep_pkg::sbep_state_t st_i,
  input  logic [7:0]            byte_i,
  input  logic                  start_i,
  input  logic [16:0]           lim_i,
  output sbep_pkg::sbep_state_t st_o,
  output sbep_pkg::sbep_res_t   res_o
);
  import sbep_pkg::*;

  sbep_state_t       s;
  logic [OFFS_W-1:0] rem;
  logic [LEN_W-1:0]  acc;
  logic [2:0]        cnt1;
  logic [LEN_W:0]    body_sum;
  logic [OFFS_W-1:0] body1;
  logic              bad_len;
  logic              corrupt;

  // Merge the low seven bits of a varint byte in at its group position.
  function automatic logic [LEN_W-1:0] shift_in(input logic [LEN_W-1:0] a,
                                                input logic [6:0] b,
                                                input logic [2:0] n);
    logic [LEN_W-1:0] v;
    v = a;
    case (n)
      3'd0:    v = a | {25'd0, b};
      3'd1:    v = a | {18'd0, b, 7'd0};
      3'd2:    v = a | {11'd0, b, 14'd0};
      3'd3:    v = a | {4'd0, b, 21'd0};
      3'd4:    v = a | {b[3:0], 28'd0};
      default: v = a;
    endcase
    return v;
  endfunction

  always_comb begin
    s = start_i ? '0 : st_i;
    st_o = s;
    res_o = '0;
    corrupt = 1'b0;
    rem = lim_i - s.offset - 17'd1;
    acc = shift_in(s.accum, byte_i[6:0], s.count);
    cnt1 = s.count + 3'd1;
    body_sum = {1'b0, s.delta_len} + {1'b0, acc};
    bad_len = (body_sum > {16'd0, rem}) || (s.shared_len > {15'd0, s.prev_key_len});
    body1 = s.body_count + 17'd1;

    if (s.phase <= PH_VAL) begin
      if (s.offset >= lim_i) begin
        st_o.phase = PH_HALT;
      end else begin
        st_o.offset = s.offset + 17'd1;
        if (s.phase <= PH_VALUE) begin
          if (s.phase == PH_SHARED && s.count == 3'd0 && rem < 17'd2) begin
            corrupt = 1'b1;
          end else if (byte_i[7]) begin
            if (cnt1 >= 3'd5 || rem == '0) begin
              corrupt = 1'b1;
            end else begin
              st_o.accum = acc;
              st_o.count = cnt1;
            end
          end else begin
            st_o.accum = '0;
            st_o.count = '0;
            if (s.phase == PH_SHARED) begin
              st_o.shared_len = acc;
              st_o.phase = PH_DELTA;
            end else if (s.phase == PH_DELTA) begin
              st_o.delta_len = acc;
              st_o.phase = PH_VALUE;
            end else if (bad_len) begin
              corrupt = 1'b1;
            end else begin
              // Lengths are now known to fit the region, so 17 bits hold them.
              st_o.value_len = acc[OFFS_W-1:0];
              st_o.prev_key_len = s.shared_len[OFFS_W-1:0] + s.delta_len[OFFS_W-1:0];
              st_o.body_count = '0;
              res_o.valid = 1'b1;
              res_o.kind = KIND_HEADER;
              res_o.shared_bytes = s.shared_len[FIELD_W-1:0];
              res_o.delta_bytes = s.delta_len[FIELD_W-1:0];
              res_o.value_bytes = acc[FIELD_W-1:0];
              if (s.delta_len == '0 && acc == '0) begin
                res_o.entry_done = 1'b1;
                res_o.block_done = (rem == '0);
                st_o.phase = (rem == '0) ? PH_HALT : PH_SHARED;
              end else begin
                st_o.phase = (s.delta_len != '0) ? PH_KEY : PH_VAL;
              end
            end
          end
        end else if (s.phase == PH_KEY) begin
          res_o.valid = 1'b1;
          res_o.kind = KIND_KEY;
          res_o.data_byte = byte_i;
          res_o.position = s.shared_len[FIELD_W-1:0] + s.body_count[FIELD_W-1:0];
          if ({15'd0, body1} >= s.delta_len) begin
            st_o.body_count = '0;
            if (s.value_len == '0) begin
              res_o.entry_done = 1'b1;
              res_o.block_done = (rem == '0);
              st_o.phase = (rem == '0) ? PH_HALT : PH_SHARED;
            end else begin
              st_o.phase = PH_VAL;
            end
          end else begin
            st_o.body_count = body1;
          end
        end else begin
          res_o.valid = 1'b1;
          res_o.kind = KIND_VALUE;
          res_o.data_byte = byte_i;
          res_o.position = s.body_count[FIELD_W-1:0];
          if (body1 >= s.value_len) begin
            st_o.body_count = '0;
            res_o.entry_done = 1'b1;
            res_o.block_done = (rem == '0);
            st_o.phase = (rem == '0) ? PH_HALT : PH_SHARED;
          end else begin
            st_o.body_count = body1;
          end
        end
      end
    end

    if (corrupt) begin
      st_o.phase = PH_HALT;
      st_o.prev_key_len = '0;
      res_o = '0;
      res_o.valid = 1'b1;
      res_o.kind = KIND_CORRUPT;
      res_o.block_done = 1'b1;
    end
  end

endmodule

[sv/sorted_block_entry_parser_core.sv]
// Sorted key-value block entry parser.
// The input stream carries one word per raw byte of a block's entry region,
// with in_tuser set on the first byte of each new block; that flag clears
// the parse state before the byte is taken. The cfg_ APB port holds the
// data_length register at byte address 0, the number of entry bytes in the
// block; bytes at or beyond it (or the build-time limit) are dropped.
// For each entry the block gives one header word with the three decoded
// lengths, then one word per key delta byte and one per value byte. A bad
// entry gives a single corruption word and parsing stops until the next
// block start. out_tlast marks a corruption word or the word ending the region.
// Throughput is one input word per cycle unless the receiver stalls; each
// byte is registered in the input stage, then makes a single pass through the
// step logic before its result is registered in the output register.
// When the receiver stalls, the output register holds its word and the
// input stage takes one more word before in_tready drops.
// Synchronous reset clears both stages, the parse state and data_length.
module sorted_block_entry_parser_core #(
  parameter int unsigned BLOCK_BYTES_LIMIT = sbep_pkg::BLOCK_BYTES_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic                            in_tuser,   // [0] start_block
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] out_byte, [23:8] position, [39:24] shared_bytes,
  // [55:40] delta_bytes, [71:56] value_bytes, [72] entry_done, rest zero
  output logic [79:0]                     out_tdata,
  output logic [1:0]                      out_tuser,  // [1:0] kind
  output logic                            out_tlast,  // block_done
  // Configuration port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sbep_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import sbep_pkg::*;

  localparam int unsigned LIM_MAX = (1 << OFFS_W) - 1;
  localparam logic [OFFS_W-1:0] LIMIT_CLAMP =
    (BLOCK_BYTES_LIMIT > LIM_MAX) ? OFFS_W'(LIM_MAX) : OFFS_W'(BLOCK_BYTES_LIMIT);

  logic [OFFS_W-1:0] data_length_r;
  logic [OFFS_W-1:0] lim;

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_start_r;
  logic              s1_adv;
  logic              s1_fire;

  sbep_state_t       st_r;
  sbep_state_t       st_nxt;
  sbep_res_t         res_nxt;
  sbep_res_t         out_res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  // Configuration register.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_DATA_LENGTH) begin
      data_length_r <= cfg_pwdata[OFFS_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_DATA_LENGTH: cfg_prdata = {{(32-OFFS_W){1'b0}}, data_length_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign lim = (data_length_r > LIMIT_CLAMP) ? LIMIT_CLAMP : data_length_r;

  // Input stage: one word of slack so a stalled result does not block input.
  assign s1_adv = !out_valid_r || out_tready;
  assign s1_fire = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Per-byte parse step.
  sbep_step u_step (
    .st_i    (st_r),
    .byte_i  (s1_byte_r),
    .start_i (s1_start_r),
    .lim_i   (lim),
    .st_o    (st_nxt),
    .res_o   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // Output register.
  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = res_nxt.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_nxt.valid) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_res_r.entry_done, out_res_r.value_bytes,
                      out_res_r.delta_bytes, out_res_r.shared_bytes,
                      out_res_r.position, out_res_r.data_byte};
  assign out_tuser = out_res_r.kind;
  assign out_tlast = out_res_r.block_done;

`include "sorted_block_entry_parser_core_assert.svh"

  // A corruption word always ends the block and never closes an entry.
  `SBEP_ASSERT_IMP(a_corrupt_ends_block, out_valid_r && out_res_r.kind == KIND_CORRUPT, out_res_r.block_done && !out_res_r.entry_done)
  // Header words carry lengths only.
  `SBEP_ASSERT_IMP(a_header_no_byte, out_valid_r && out_res_r.kind == KIND_HEADER, out_res_r.data_byte == 8'd0 && out_res_r.position == 16'd0)
  // A held input word stays put while the output side is stalled.
  `SBEP_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r)
  // A varint never collects more than four continuation bytes.
  `SBEP_ASSERT_IMP(a_varint_count, s1_valid_r, st_r.count <= 3'd4)

endmodule
